[hdl/irm_pkg.sv]
// irm_pkg: shared constants, types and the heap entry compare for the room allocator.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package irm_pkg;

  // Default heap capacity (rooms that can be open at once)
  localparam int MAX_ROOMS = 1024;

  // Fixed field widths
  localparam int DEP_W      = 32;
  localparam int IDX_W      = 16;
  localparam int ROOM_OUT_W = 11;
  // Room numbers are zero-extended to this width before a compare
  localparam int CMP_W      = 32;

  // Walk operations that travel down the level chain
  localparam logic OP_SIFT   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Control half of the token handed from one level to the next
  typedef struct packed {
    logic valid;
    logic op;
  } irm_ctl_t;

  // Heap order: departure first, then room number
  function automatic logic entry_less(input logic [DEP_W-1:0] adep,
                                      input logic [CMP_W-1:0] aroom,
                                      input logic [DEP_W-1:0] bdep,
                                      input logic [CMP_W-1:0] broom);
    logic lt;
    if (adep != bdep) begin
      lt = (adep < bdep);
    end else begin
      lt = (aroom < broom);
    end
    return lt;
  endfunction

endpackage

[hdl/irm_book_if.sv]
// irm_book_if: booking channel (valid/ready plus one booking per beat).
// Depends on irm_pkg for field widths.
`timescale 1ns / 1ps

interface irm_book_if;
  logic                          valid;
  logic                          ready;
  logic [irm_pkg::DEP_W-1:0]     arrival_time;
  logic [irm_pkg::DEP_W-1:0]     departure_time;
  logic [irm_pkg::IDX_W-1:0]     booking_index;

  modport source (output valid, arrival_time, departure_time, booking_index, input ready);
  modport sink   (input valid, arrival_time, departure_time, booking_index, output ready);
endinterface

[hdl/irm_result_if.sv]
// irm_result_if: result channel (valid/ready plus one room assignment per beat).
// Depends on irm_pkg for field widths.
`timescale 1ns / 1ps

interface irm_result_if;
  logic                             valid;
  logic                             ready;
  logic [irm_pkg::IDX_W-1:0]        result_index;
  logic [irm_pkg::ROOM_OUT_W-1:0]   room_number;
  logic [irm_pkg::ROOM_OUT_W-1:0]   rooms_opened;
  logic                             overflow;

  modport source (output valid, result_index, room_number, rooms_opened, overflow, input ready);
  modport sink   (input valid, result_index, room_number, rooms_opened, overflow, output ready);
endinterface

[hdl/interval_room_allocator.sv]
// interval_room_allocator: greedy interval partitioning over a min-heap of busy rooms.
// Depends on irm_pkg, irm_book_if, irm_result_if and irm_level.
`timescale 1ns / 1ps

// Bookings must come in ordered by arrival. Each booking beat yields one result
// beat: the booking's index, its room (reused from the earliest-freed room when
// the arrival is strictly after that room's departure, else a newly opened room),
// the number of rooms open and an overflow flag when all MAX_ROOMS are taken.
// The heap root sits in a register here; each deeper level is one cell of a
// chain that owns that level's nodes and passes the sift or insert walk to the
// next level below, each level doing a memory read, then a compare and write.
// A booking holds the input until its walk through the level chain ends, so
// the walk depth sets how long it waits. Bookings that need no walk (first
// room, overflow) skip the chain. The heap needs no clearing after reset, and
// the next booking is taken while one result waits in the output register.
module interval_room_allocator #(
  parameter int MAX_ROOMS = irm_pkg::MAX_ROOMS
) (
  input logic          clk,
  input logic          rst,
  irm_book_if.sink     bookings,
  irm_result_if.source results
);

  localparam int CW     = $clog2(MAX_ROOMS+1);
  localparam int SW     = $clog2(CW);
  localparam int LEVELS = CW;
  localparam int OW     = irm_pkg::ROOM_OUT_W;
  localparam int DW     = irm_pkg::DEP_W;
  localparam int XW     = irm_pkg::IDX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [DW-1:0] root_dep;
  logic [CW-1:0] root_room;

  // chain wiring: index l is the output of level l (index 0 is the root)
  irm_pkg::irm_ctl_t tok   [LEVELS];
  logic [DW-1:0]     tdep  [LEVELS];
  logic [CW-1:0]     troom [LEVELS];
  logic [CW-1:0]     tj    [LEVELS];
  logic [CW-1:0]     tpp1  [LEVELS];
  logic [SW-1:0]     tsh   [LEVELS];
  logic              wbv   [LEVELS+1];
  logic [CW-1:0]     wbi   [LEVELS+1];
  logic [DW-1:0]     wbd   [LEVELS+1];
  logic [CW-1:0]     wbr   [LEVELS+1];
  logic [LEVELS-1:1] fin_vec;

  // nothing below the deepest level
  assign wbv[LEVELS] = 1'b0;
  assign wbi[LEVELS] = '0;
  assign wbd[LEVELS] = '0;
  assign wbr[LEVELS] = '0;

  for (genvar l = 1; l < LEVELS; l++) begin : g_level
    irm_level #(
      .MAX_ROOMS (MAX_ROOMS),
      .LEVEL     (l)
    ) u_level (
      .clk            (clk),
      .rst            (rst),
      .count          (count),
      .tok_in         (tok[l-1]),
      .tok_dep_in     (tdep[l-1]),
      .tok_room_in    (troom[l-1]),
      .tok_j_in       (tj[l-1]),
      .tok_pp1_in     (tpp1[l-1]),
      .tok_sh_in      (tsh[l-1]),
      .tok_out        (tok[l]),
      .tok_dep_out    (tdep[l]),
      .tok_room_out   (troom[l]),
      .tok_j_out      (tj[l]),
      .tok_pp1_out    (tpp1[l]),
      .tok_sh_out     (tsh[l]),
      .wb_valid       (wbv[l]),
      .wb_idx         (wbi[l]),
      .wb_dep         (wbd[l]),
      .wb_room        (wbr[l]),
      .child_wb_valid (wbv[l+1]),
      .child_wb_idx   (wbi[l+1]),
      .child_wb_dep   (wbd[l+1]),
      .child_wb_room  (wbr[l+1]),
      .fin            (fin_vec[l])
    );
  end

  // highest set bit: depth of the new slot in the tree
  function automatic logic [SW-1:0] top_bit(input logic [CW-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) begin
        r = SW'(i);
      end
    end
    return r;
  endfunction

  // result staging: one pending beat plus the output register
  logic          pend_valid;
  logic [XW-1:0] pend_index;
  logic [OW-1:0] pend_room;
  logic [OW-1:0] pend_opened;
  logic          pend_ovf;
  logic          ob_valid;
  logic [XW-1:0] ob_index;
  logic [OW-1:0] ob_room;
  logic [OW-1:0] ob_opened;
  logic          ob_ovf;

  assign bookings.ready       = (state == ST_IDLE) && !pend_valid;
  assign results.valid        = ob_valid;
  assign results.result_index = ob_index;
  assign results.room_number  = ob_room;
  assign results.rooms_opened = ob_opened;
  assign results.overflow     = ob_ovf;

  // booking decision against the root
  logic          fire, reuse, can_open, n_lt_root, move;
  logic [CW-1:0] new_room;
  logic [SW-1:0] depth;

  assign fire      = bookings.valid && bookings.ready;
  assign reuse     = (count != '0) && (bookings.arrival_time > root_dep);
  assign can_open  = (count < CW'(MAX_ROOMS));
  assign new_room  = count + 1'b1;
  assign depth     = top_bit(new_room);
  assign n_lt_root = irm_pkg::entry_less(bookings.departure_time,
                                         irm_pkg::CMP_W'(new_room),
                                         root_dep,
                                         irm_pkg::CMP_W'(root_room));
  assign move      = pend_valid && (!ob_valid || results.ready);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      ob_valid   <= 1'b0;
      tok[0]     <= '0;
    end else begin
      if (move) begin
        ob_valid   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (results.ready) begin
        ob_valid <= 1'b0;
      end
      if ((state == ST_WALK) && (|fin_vec)) begin
        state <= ST_IDLE;
      end
      // walk start: sift after a reuse, insert below a non-empty heap
      if (fire && reuse) begin
        tok[0] <= '{valid: 1'b1, op: irm_pkg::OP_SIFT};
      end else if (fire && can_open && (count != '0)) begin
        tok[0] <= '{valid: 1'b1, op: irm_pkg::OP_INSERT};
      end else begin
        tok[0] <= '0;
      end
      if (fire) begin
        pend_valid <= 1'b1;
        if (reuse) begin
          state <= ST_WALK;
        end else if (can_open) begin
          count <= new_room;
          if (count != '0) begin
            state <= ST_WALK;
          end
        end
      end
    end
  end

  // root entry, walk payload and result beats
  always_ff @(posedge clk) begin
    if (wbv[1]) begin
      root_dep  <= wbd[1];
      root_room <= wbr[1];
    end
    if (move) begin
      ob_index  <= pend_index;
      ob_room   <= pend_room;
      ob_opened <= pend_opened;
      ob_ovf    <= pend_ovf;
    end
    if (fire) begin
      pend_index <= bookings.booking_index;
      tj[0]      <= '0;
      tpp1[0]    <= new_room;
      tsh[0]     <= depth - 1'b1;
      if (reuse) begin
        root_dep    <= bookings.departure_time;
        tdep[0]     <= bookings.departure_time;
        troom[0]    <= root_room;
        pend_room   <= OW'(root_room);
        pend_opened <= OW'(count);
        pend_ovf    <= 1'b0;
      end else if (can_open) begin
        pend_room   <= OW'(new_room);
        pend_opened <= OW'(new_room);
        pend_ovf    <= 1'b0;
        if ((count == '0) || n_lt_root) begin
          // new room takes the root; old root walks down the path
          root_dep  <= bookings.departure_time;
          root_room <= new_room;
          tdep[0]   <= root_dep;
          troom[0]  <= root_room;
        end else begin
          tdep[0]  <= bookings.departure_time;
          troom[0] <= new_room;
        end
      end else begin
        pend_room   <= '0;
        pend_opened <= OW'(count);
        pend_ovf    <= 1'b1;
      end
    end
  end

endmodule

[hdl/irm_level.sv]
// irm_level: one heap level below the root. Holds the level's nodes in two
// sibling memories and moves sift-down and insert walks one level further.
// Depends on irm_pkg.
`timescale 1ns / 1ps

module irm_level #(
  parameter int MAX_ROOMS = irm_pkg::MAX_ROOMS,
  parameter int LEVEL     = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(MAX_ROOMS+1)-1:0]     count,
  // walk token from the level above
  input  irm_pkg::irm_ctl_t                  tok_in,
  input  logic [irm_pkg::DEP_W-1:0]          tok_dep_in,
  input  logic [$clog2(MAX_ROOMS+1)-1:0]     tok_room_in,
  input  logic [$clog2(MAX_ROOMS+1)-1:0]     tok_j_in,
  input  logic [$clog2(MAX_ROOMS+1)-1:0]     tok_pp1_in,
  input  logic [$clog2($clog2(MAX_ROOMS+1))-1:0] tok_sh_in,
  // walk token to the level below
  output irm_pkg::irm_ctl_t                  tok_out,
  output logic [irm_pkg::DEP_W-1:0]          tok_dep_out,
  output logic [$clog2(MAX_ROOMS+1)-1:0]     tok_room_out,
  output logic [$clog2(MAX_ROOMS+1)-1:0]     tok_j_out,
  output logic [$clog2(MAX_ROOMS+1)-1:0]     tok_pp1_out,
  output logic [$clog2($clog2(MAX_ROOMS+1))-1:0] tok_sh_out,
  // parent slot write-back to the level above
  output logic                               wb_valid,
  output logic [$clog2(MAX_ROOMS+1)-1:0]     wb_idx,
  output logic [irm_pkg::DEP_W-1:0]          wb_dep,
  output logic [$clog2(MAX_ROOMS+1)-1:0]     wb_room,
  // write-back coming up from the level below
  input  logic                               child_wb_valid,
  input  logic [$clog2(MAX_ROOMS+1)-1:0]     child_wb_idx,
  input  logic [irm_pkg::DEP_W-1:0]          child_wb_dep,
  input  logic [$clog2(MAX_ROOMS+1)-1:0]     child_wb_room,
  output logic                               fin
);

  localparam int CW    = $clog2(MAX_ROOMS+1);
  localparam int SW    = $clog2(CW);
  localparam int EW    = irm_pkg::DEP_W + CW;
  localparam bit LAST  = (LEVEL == CW-1);
  localparam int FIRST = (1 << LEVEL) - 1;
  localparam int SPAN  = ((MAX_ROOMS - FIRST) < (1 << LEVEL)) ? (MAX_ROOMS - FIRST)
                                                               : (1 << LEVEL);
  localparam int ROWS  = (SPAN + 1) / 2;
  localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  // sibling pairs: left child in mem_l, right child in mem_r, row = parent index
  logic [EW-1:0] mem_l [ROWS];
  logic [EW-1:0] mem_r [ROWS];

  // stage A: token held while its row is read
  irm_pkg::irm_ctl_t s_tok;
  logic [irm_pkg::DEP_W-1:0] s_dep;
  logic [CW-1:0] s_room;
  logic [CW-1:0] s_j;
  logic [CW-1:0] s_pp1;
  logic [SW-1:0] s_sh;
  logic [EW-1:0] rd_l;
  logic [EW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_tok <= '0;
    end else begin
      s_tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    s_dep  <= tok_dep_in;
    s_room <= tok_room_in;
    s_j    <= tok_j_in;
    s_pp1  <= tok_pp1_in;
    s_sh   <= tok_sh_in;
    if (tok_in.valid) begin
      rd_l <= mem_l[tok_j_in[AW-1:0]];
      rd_r <= mem_r[tok_j_in[AW-1:0]];
    end
  end

  // stage B: compares on the carried entry and the sibling pair
  logic [CW+1:0] posl, posr, cnt_x;
  logic l_ok, r_ok;
  logic [irm_pkg::CMP_W-1:0] xr, lr, rr, er;
  logic lt_lx, lt_rx, lt_rl, take_l, pick_l, pick_r;
  logic ins_side, ins_lt, target;
  logic [EW-1:0] ins_e;

  assign posl  = (CW+2)'(FIRST) + {1'b0, s_j, 1'b0};
  assign posr  = posl + 1'b1;
  assign cnt_x = (CW+2)'(count);
  assign l_ok  = (posl < cnt_x);
  assign r_ok  = (posr < cnt_x);

  assign xr = irm_pkg::CMP_W'(s_room);
  assign lr = irm_pkg::CMP_W'(rd_l[CW-1:0]);
  assign rr = irm_pkg::CMP_W'(rd_r[CW-1:0]);

  assign lt_lx = irm_pkg::entry_less(rd_l[EW-1:CW], lr, s_dep, xr);
  assign lt_rx = irm_pkg::entry_less(rd_r[EW-1:CW], rr, s_dep, xr);
  assign lt_rl = irm_pkg::entry_less(rd_r[EW-1:CW], rr, rd_l[EW-1:CW], lr);

  // smallest of parent, left, right; right replaces the running best only when strictly smaller
  assign take_l = l_ok && lt_lx;
  assign pick_r = r_ok && (take_l ? lt_rl : lt_rx);
  assign pick_l = take_l && !pick_r;

  // insert: follow the path to the new slot, bit by bit of (position + 1)
  assign ins_side = s_pp1[s_sh];
  assign ins_e    = ins_side ? rd_r : rd_l;
  assign er       = irm_pkg::CMP_W'(ins_e[CW-1:0]);
  assign ins_lt   = irm_pkg::entry_less(s_dep, xr, ins_e[EW-1:CW], er);
  assign target   = (s_sh == '0);

  irm_pkg::irm_ctl_t tok_next;
  logic [irm_pkg::DEP_W-1:0] dep_next, wb_dep_next;
  logic [CW-1:0] room_next, j_next, sh_room_unused, wb_room_next;
  logic [SW-1:0] sh_next;
  logic wb_next, fin_next, loc_we, loc_half;
  logic [EW-1:0] loc_data;

  always_comb begin
    tok_next       = '0;
    dep_next       = s_dep;
    room_next      = s_room;
    j_next         = s_j;
    sh_next        = s_sh;
    sh_room_unused = '0;
    wb_next        = 1'b0;
    wb_dep_next    = s_dep;
    wb_room_next   = s_room;
    fin_next       = 1'b0;
    loc_we         = 1'b0;
    loc_half       = 1'b0;
    loc_data       = {s_dep, s_room};
    if (s_tok.valid) begin
      if (s_tok.op == irm_pkg::OP_SIFT) begin
        // parent slot always gets the winner; carried entry moves down on a swap
        wb_next = 1'b1;
        if (pick_l || pick_r) begin
          wb_dep_next  = pick_r ? rd_r[EW-1:CW] : rd_l[EW-1:CW];
          wb_room_next = pick_r ? rd_r[CW-1:0]  : rd_l[CW-1:0];
          j_next       = {s_j[CW-2:0], pick_r};
          if (LAST) begin
            loc_we   = 1'b1;
            loc_half = pick_r;
            fin_next = 1'b1;
          end else begin
            tok_next = s_tok;
          end
        end else begin
          fin_next = 1'b1;
        end
      end else begin
        loc_half = ins_side;
        j_next   = {s_j[CW-2:0], ins_side};
        sh_next  = s_sh - 1'b1;
        if (target) begin
          loc_we   = 1'b1;
          fin_next = 1'b1;
        end else begin
          tok_next = s_tok;
          if (ins_lt) begin
            // carried entry takes this node, old node continues down
            loc_we    = 1'b1;
            dep_next  = ins_e[EW-1:CW];
            room_next = ins_e[CW-1:0];
          end
        end
      end
    end
  end

  // node writes: from the level below, or this level's own decision
  logic wr_en, wr_half;
  logic [AW-1:0] wr_row;
  logic [EW-1:0] wr_data;

  always_comb begin
    if (child_wb_valid) begin
      wr_en   = 1'b1;
      wr_half = child_wb_idx[0];
      wr_row  = child_wb_idx[AW:1];
      wr_data = {child_wb_dep, child_wb_room};
    end else begin
      wr_en   = loc_we;
      wr_half = loc_half;
      wr_row  = s_j[AW-1:0];
      wr_data = loc_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_half) begin
        mem_r[wr_row] <= wr_data;
      end else begin
        mem_l[wr_row] <= wr_data;
      end
    end
  end

  // registered hand-off to the neighbors
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= '0;
      wb_valid <= 1'b0;
      fin      <= 1'b0;
    end else begin
      tok_out  <= tok_next;
      wb_valid <= wb_next;
      fin      <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_dep_out  <= dep_next;
    tok_room_out <= room_next | sh_room_unused;
    tok_j_out    <= j_next;
    tok_pp1_out  <= s_pp1;
    tok_sh_out   <= sh_next;
    wb_idx       <= s_j;
    wb_dep       <= wb_dep_next;
    wb_room      <= wb_room_next;
  end

endmodule

[hdl/irm_checker.sv]
// irm_checker: port-level assertions for the room allocator, bound to the top level.
// Depends on interval_room_allocator (bind target) and irm_pkg.
`timescale 1ns / 1ps

module irm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           bk_valid,
  input logic                           bk_ready,
  input logic                           rs_valid,
  input logic                           rs_ready,
  input logic [irm_pkg::ROOM_OUT_W-1:0] rs_room,
  input logic                           rs_overflow
);

  // bookings taken but not yet answered
  logic [1:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'(bk_valid && bk_ready) - 2'(rs_valid && rs_ready);
    end
  end

  // a booking beat always blocks the input in the cycle after it
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (bk_valid && bk_ready) |=> !bk_ready)
    else $error("input ready right after a booking beat");

  // a stalled result stays up
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rs_valid && !rs_ready) |=> rs_valid)
    else $error("result dropped while stalled");

  // overflow never carries a room
  a_ovf_no_room: assert property (@(posedge clk) disable iff (rst)
    (rs_valid && rs_overflow) |-> (rs_room == '0))
    else $error("overflow result with a room number");

  // no result without a booking behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rs_valid |-> (outstanding != 2'd0))
    else $error("result beat without an open booking");

  // reset leaves the block empty and ready
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!rs_valid && bk_ready))
    else $error("block not empty after reset");

endmodule

bind interval_room_allocator irm_checker u_irm_checker (
  .clk         (clk),
  .rst         (rst),
  .bk_valid    (bookings.valid),
  .bk_ready    (bookings.ready),
  .rs_valid    (results.valid),
  .rs_ready    (results.ready),
  .rs_room     (results.room_number),
  .rs_overflow (results.overflow)
);
